>>> design/fspa_pkg.sv
// ----------------------------------------------------------------------------
// fspa_pkg
// Shared constants and codes for the fixed slot pool allocator.
// ----------------------------------------------------------------------------
package fspa_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int OUT_IDX_W = 6;
  localparam int OUT_CNT_W = 7;
  localparam int STATUS_W  = 2;

  typedef enum logic [0:0] {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_BASE_ADDRESS = 1'b0,
    REG_OBJECT_SIZE  = 1'b1
  } reg_index_t;

endpackage

>>> design/fixed_slot_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_unit
// Pool allocator for equal-size slots: grants the lowest free slot, frees the
// lowest busy slot at a given address, and tracks the busy count.
// ----------------------------------------------------------------------------
// After reset a clearing pass walks the busy memory, one slot per cycle, over
// all SLOTS (64) slots while no command is taken; register writes are taken as
// ever. Each command then scans the busy memory, one slot per cycle through
// its single read port, and stops at the first free slot (allocate) or the
// first busy slot whose address matches (release), or at the last slot for a
// full pool or a miss, and then loads the result register. The next command
// is taken once the result is loaded, even while that result still waits
// downstream. Slot addresses are base_address + index * object_size modulo
// 2^32.
module fixed_slot_pool_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] release_address
  input  logic [0:0]  s_tuser,   // [0] command
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] slot_address, [37:32] slot_index,
                                 // [44:38] busy_count, [47:45] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_PUSH
  } state_t;

  state_t state;

  logic [fspa_pkg::ADDR_W-1:0] base_address;
  logic [fspa_pkg::SIZE_W-1:0] object_size;

  // busy memory
  logic                       busy_mem [fspa_pkg::SLOTS];
  logic                       mem_we;
  logic [fspa_pkg::IDX_W-1:0] mem_wa;
  logic                       mem_wd;
  logic                       busy_rd;

  logic [fspa_pkg::IDX_W:0]    clr_idx;
  logic [fspa_pkg::IDX_W:0]    rd_idx;
  logic [fspa_pkg::IDX_W-1:0]  chk_idx;
  logic                        chk_vld;
  logic [fspa_pkg::ADDR_W-1:0] issue_addr;
  logic [fspa_pkg::ADDR_W-1:0] chk_addr;

  fspa_pkg::cmd_t              cmd_q;
  logic [fspa_pkg::ADDR_W-1:0] want_q;
  logic [fspa_pkg::CNT_W-1:0]  busy_total;

  fspa_pkg::status_t           res_status;
  logic [fspa_pkg::ADDR_W-1:0] res_addr;
  logic [fspa_pkg::IDX_W-1:0]  res_idx;

  logic                        hit;
  logic                        last_chk;

  assign pready   = 1'b1;
  assign s_tready = (state == S_IDLE);

  assign hit = chk_vld && ((cmd_q == fspa_pkg::CMD_ALLOC) ? !busy_rd
                                                          : (busy_rd && chk_addr == want_q));
  assign last_chk = chk_vld && (chk_idx == fspa_pkg::IDX_W'(fspa_pkg::SLOTS - 1));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = chk_idx;
    mem_wd = 1'b0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_idx[fspa_pkg::IDX_W-1:0];
    end else if (state == S_SCAN && hit) begin
      mem_we = 1'b1;
      mem_wd = (cmd_q == fspa_pkg::CMD_ALLOC);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      busy_mem[mem_wa] <= mem_wd;
    end
    busy_rd <= busy_mem[rd_idx[fspa_pkg::IDX_W-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      object_size  <= fspa_pkg::SIZE_W'(64);
    end else if (psel && penable && pwrite && pready) begin
      unique case (fspa_pkg::reg_index_t'(paddr[2]))
        fspa_pkg::REG_BASE_ADDRESS: base_address <= pwdata;
        fspa_pkg::REG_OBJECT_SIZE:  object_size  <= pwdata[fspa_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (fspa_pkg::reg_index_t'(paddr[2]))
      fspa_pkg::REG_BASE_ADDRESS: prdata = base_address;
      fspa_pkg::REG_OBJECT_SIZE:  prdata = {{(32 - fspa_pkg::SIZE_W){1'b0}}, object_size};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      busy_total <= '0;
      chk_vld    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_PUSH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (fspa_pkg::IDX_W + 1)'(fspa_pkg::SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q      <= fspa_pkg::cmd_t'(s_tuser[0]);
            want_q     <= s_tdata;
            rd_idx     <= '0;
            issue_addr <= base_address;
            chk_vld    <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue the next read while checking the previous one
          chk_vld    <= !hit && !last_chk &&
                        (rd_idx < (fspa_pkg::IDX_W + 1)'(fspa_pkg::SLOTS));
          chk_idx    <= rd_idx[fspa_pkg::IDX_W-1:0];
          chk_addr   <= issue_addr;
          rd_idx     <= rd_idx + 1'b1;
          issue_addr <= issue_addr + {{(fspa_pkg::ADDR_W - fspa_pkg::SIZE_W){1'b0}},
                                      object_size};
          if (hit) begin
            res_status <= fspa_pkg::ST_OK;
            res_idx    <= chk_idx;
            res_addr   <= chk_addr;
            if (cmd_q == fspa_pkg::CMD_ALLOC) begin
              busy_total <= busy_total + 1'b1;
            end else if (busy_total != '0) begin
              busy_total <= busy_total - 1'b1;
            end
            state   <= S_PUSH;
          end else if (last_chk) begin
            res_status <= (cmd_q == fspa_pkg::CMD_ALLOC) ? fspa_pkg::ST_FULL
                                                         : fspa_pkg::ST_NOT_FOUND;
            res_idx    <= '0;
            res_addr   <= '0;
            state      <= S_PUSH;
          end
        end
        S_PUSH: begin
          // hold until the result register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {3'b000,
                         fspa_pkg::OUT_CNT_W'(busy_total),
                         fspa_pkg::OUT_IDX_W'(res_idx),
                         res_addr};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    busy_total <= fspa_pkg::CNT_W'(fspa_pkg::SLOTS))
    else $error("busy count exceeds pool size");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && res_status == fspa_pkg::ST_FULL)
      |-> busy_total == fspa_pkg::CNT_W'(fspa_pkg::SLOTS))
    else $error("pool full reported with free slots");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != fspa_pkg::ST_OK) |-> m_tdata[37:0] == '0)
    else $error("error result carries nonzero address or index");

  a_scan_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_SCAN && $stable(busy_total)))
    else $error("count changed on command accept");

endmodule
